/* hw/rtl/qrpm_pkg.sv */
// qrpm_pkg: shared constants, register codes and pipeline control type
// for the quad rate pid mixer; no dependencies
`default_nettype none

package qrpm_pkg;

    // fixed-point formats
    localparam int RATE_FRAC_BITS = 4;
    localparam int KI_FRAC_BITS   = 8;

    // field widths
    localparam int WANT_W     = 12;
    localparam int MEAS_W     = 16;
    localparam int PULSE_W    = 12;
    localparam int GAIN_W     = 8;
    localparam int LIMIT_W    = 10;
    localparam int DRIVE_W    = 11;
    localparam int ERR_W      = 14;
    localparam int INTEG_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    // pipeline: five lane stages then the mixer stage
    localparam int NUM_STAGES  = 6;
    localparam int DRIVE_STAGE = 4;
    localparam int MIX_STAGE   = 5;

    // error saturation bounds
    localparam logic signed [ERR_W-1:0] ERR_MAX = 14'sh1FFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = 14'sh2000;

    // arm handling
    localparam logic [PULSE_W-1:0] ARM_THRESHOLD = 12'd1100;
    localparam logic [PULSE_W-1:0] KILL_PULSE    = 12'd1000;

    // register reset values
    localparam logic [GAIN_W-1:0]  KP_PR_RST     = 8'd2;
    localparam logic [GAIN_W-1:0]  KD_PR_RST     = 8'd18;
    localparam logic [GAIN_W-1:0]  KP_YAW_RST    = 8'd4;
    localparam logic [GAIN_W-1:0]  KD_YAW_RST    = 8'd0;
    localparam logic [GAIN_W-1:0]  KI_RST        = 8'd5;
    localparam logic [LIMIT_W-1:0] AXIS_LIM_RST  = 10'd250;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd1100;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KP_PITCH_ROLL = 3'd0,
        CFG_KD_PITCH_ROLL = 3'd1,
        CFG_KP_YAW        = 3'd2,
        CFG_KD_YAW        = 3'd3,
        CFG_KI_GAIN       = 3'd4,
        CFG_AXIS_LIMIT    = 3'd5,
        CFG_MIN_PULSE     = 3'd6,
        CFG_MAX_PULSE     = 3'd7
    } cfg_reg_t;

    // per-stage load strobes shared by all lanes and the mixer
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/quad_rate_pid_mixer_unit.sv */
// throughput: one beat per cycle while m_tready applies no back-pressure, set by the six-stage
// pipeline (three axis lanes of five stages, then the mixer/output register)
// each axis updates its previous error and integrator once per beat, in order
// reset: pipeline empty, integrators and previous errors zero, config at defaults
// top level of the quad rate pid mixer; depends on qrpm_pkg, qrpm_axis, qrpm_mixer
`default_nettype none

module quad_rate_pid_mixer_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // want_pitch, want_roll, want_yaw, meas_pitch, meas_roll, meas_yaw,
    // throttle, arm_pulse, zero fill
    input  wire logic [111:0]                          s_tdata,
    // output stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // motor1_pulse, motor2_pulse, motor3_pulse, motor4_pulse,
    // pitch_drive, roll_drive, yaw_drive, zero fill
    output logic [87:0]                                m_tdata,
    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [qrpm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [qrpm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int NS  = qrpm_pkg::NUM_STAGES;
    localparam int PW  = qrpm_pkg::PULSE_W;
    localparam int GW  = qrpm_pkg::GAIN_W;
    localparam int DW  = qrpm_pkg::DRIVE_W;
    localparam int WW  = qrpm_pkg::WANT_W;
    localparam int MW  = qrpm_pkg::MEAS_W;
    localparam int NSIDE = qrpm_pkg::MIX_STAGE;

    // config registers
    logic [GW-1:0]                    kp_pr_reg, kd_pr_reg, kp_yaw_reg, kd_yaw_reg, ki_reg;
    logic [qrpm_pkg::LIMIT_W-1:0]     lim_reg;
    logic [PW-1:0]                    min_reg, max_reg;

    // pipeline control
    logic [NS-1:0]        v_reg, v_next;
    logic [NS:0]          rdy;
    qrpm_pkg::pipe_ctl_t  ctl;

    // throttle and arm flag travel beside the lanes
    logic [PW-1:0]        thr_reg [NSIDE];
    logic [NSIDE-1:0]     arm_reg;

    // unpacked input fields
    logic signed [WW-1:0] want_pitch, want_roll, want_yaw;
    logic signed [MW-1:0] meas_pitch, meas_roll, meas_yaw;
    logic [PW-1:0]        throttle, arm_pulse;

    logic signed [DW-1:0] pitch_lane, roll_lane, yaw_lane;
    logic [PW-1:0]        motor1_pulse, motor2_pulse, motor3_pulse, motor4_pulse;
    logic signed [DW-1:0] pitch_drive, roll_drive, yaw_drive;

    assign want_pitch = $signed(s_tdata[11:0]);
    assign want_roll  = $signed(s_tdata[23:12]);
    assign want_yaw   = $signed(s_tdata[35:24]);
    assign meas_pitch = $signed(s_tdata[51:36]);
    assign meas_roll  = $signed(s_tdata[67:52]);
    assign meas_yaw   = $signed(s_tdata[83:68]);
    assign throttle   = s_tdata[95:84];
    assign arm_pulse  = s_tdata[107:96];

    // config write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_pr_reg  <= qrpm_pkg::KP_PR_RST;
            kd_pr_reg  <= qrpm_pkg::KD_PR_RST;
            kp_yaw_reg <= qrpm_pkg::KP_YAW_RST;
            kd_yaw_reg <= qrpm_pkg::KD_YAW_RST;
            ki_reg     <= qrpm_pkg::KI_RST;
            lim_reg    <= qrpm_pkg::AXIS_LIM_RST;
            min_reg    <= qrpm_pkg::MIN_PULSE_RST;
            max_reg    <= qrpm_pkg::MAX_PULSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (qrpm_pkg::cfg_reg_t'(cfg_addr))
                qrpm_pkg::CFG_KP_PITCH_ROLL: kp_pr_reg  <= cfg_wdata[GW-1:0];
                qrpm_pkg::CFG_KD_PITCH_ROLL: kd_pr_reg  <= cfg_wdata[GW-1:0];
                qrpm_pkg::CFG_KP_YAW:        kp_yaw_reg <= cfg_wdata[GW-1:0];
                qrpm_pkg::CFG_KD_YAW:        kd_yaw_reg <= cfg_wdata[GW-1:0];
                qrpm_pkg::CFG_KI_GAIN:       ki_reg     <= cfg_wdata[GW-1:0];
                qrpm_pkg::CFG_AXIS_LIMIT:    lim_reg    <= cfg_wdata[qrpm_pkg::LIMIT_W-1:0];
                qrpm_pkg::CFG_MIN_PULSE:     min_reg    <= cfg_wdata[PW-1:0];
                qrpm_pkg::CFG_MAX_PULSE:     max_reg    <= cfg_wdata[PW-1:0];
                default: ;
            endcase
        end
    end

    // a stage takes a new beat when it is empty or its beat moves on;
    // bubbles collapse so input is taken while a result waits
    always_comb
    begin
        rdy[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        ctl.load[0] = rdy[0] && s_tvalid;
        v_next[0]   = rdy[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            ctl.load[i] = rdy[i] && v_reg[i-1];
            v_next[i]   = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // side pipe for throttle and arm decision
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            thr_reg[0] <= throttle;
            arm_reg[0] <= (arm_pulse >= qrpm_pkg::ARM_THRESHOLD);
        end
        for (int i = 1; i < NSIDE; i++)
        begin
            if (ctl.load[i])
            begin
                thr_reg[i] <= thr_reg[i-1];
                arm_reg[i] <= arm_reg[i-1];
            end
        end
    end

    // three axis lanes side by side
    qrpm_axis u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .want  (want_pitch),
        .meas  (meas_pitch),
        .kp    (kp_pr_reg),
        .kd    (kd_pr_reg),
        .ki    (ki_reg),
        .limit (lim_reg),
        .drive (pitch_lane)
    );

    qrpm_axis u_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .want  (want_roll),
        .meas  (meas_roll),
        .kp    (kp_pr_reg),
        .kd    (kd_pr_reg),
        .ki    (ki_reg),
        .limit (lim_reg),
        .drive (roll_lane)
    );

    qrpm_axis u_yaw (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .want  (want_yaw),
        .meas  (meas_yaw),
        .kp    (kp_yaw_reg),
        .kd    (kd_yaw_reg),
        .ki    (ki_reg),
        .limit (lim_reg),
        .drive (yaw_lane)
    );

    // merge stage: motor mix, bounds, kill, output register
    qrpm_mixer u_mixer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .throttle     (thr_reg[NSIDE-1]),
        .armed        (arm_reg[NSIDE-1]),
        .pitch_in     (pitch_lane),
        .roll_in      (roll_lane),
        .yaw_in       (yaw_lane),
        .min_pulse    (min_reg),
        .max_pulse    (max_reg),
        .motor1_pulse (motor1_pulse),
        .motor2_pulse (motor2_pulse),
        .motor3_pulse (motor3_pulse),
        .motor4_pulse (motor4_pulse),
        .pitch_drive  (pitch_drive),
        .roll_drive   (roll_drive),
        .yaw_drive    (yaw_drive)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {7'b0000000, yaw_drive, roll_drive, pitch_drive,
                       motor4_pulse, motor3_pulse, motor2_pulse, motor1_pulse};

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted beat missing from first stage");

    a_beat_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(v_reg) == $past($countones(v_reg))
                  + $past(int'(s_tvalid && s_tready))
                  - $past(int'(m_tvalid && m_tready))))
        else $error("beat lost or duplicated in pipeline");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] && !m_tready |=> v_reg[NS-1])
        else $error("waiting result dropped");

endmodule

`default_nettype wire

/* hw/rtl/qrpm_axis.sv */
// qrpm_axis: one axis lane, rate error through clamped pid drive in five stages
// depends on qrpm_pkg
`default_nettype none

module qrpm_axis (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire qrpm_pkg::pipe_ctl_t                     ctl,
    input  wire logic signed [qrpm_pkg::WANT_W-1:0]      want,
    input  wire logic signed [qrpm_pkg::MEAS_W-1:0]      meas,
    input  wire logic        [qrpm_pkg::GAIN_W-1:0]      kp,
    input  wire logic        [qrpm_pkg::GAIN_W-1:0]      kd,
    input  wire logic        [qrpm_pkg::GAIN_W-1:0]      ki,
    input  wire logic        [qrpm_pkg::LIMIT_W-1:0]     limit,
    output logic signed      [qrpm_pkg::DRIVE_W-1:0]     drive
);

    localparam int R       = qrpm_pkg::RATE_FRAC_BITS;
    localparam int K       = qrpm_pkg::KI_FRAC_BITS;
    localparam int ERR_W   = qrpm_pkg::ERR_W;
    localparam int INTEG_W = qrpm_pkg::INTEG_W;
    localparam int WSH_W   = qrpm_pkg::WANT_W + R;
    localparam int DIFF_W  = ((WSH_W > qrpm_pkg::MEAS_W) ? WSH_W : qrpm_pkg::MEAS_W) + 1;
    localparam int PROD_W  = qrpm_pkg::GAIN_W + 1 + ERR_W;
    localparam int DPROD_W = PROD_W + 1;
    localparam int PD_W    = DPROD_W + 1;
    localparam int SUM_W   = (((PD_W + K) > INTEG_W) ? (PD_W + K) : INTEG_W) + 1;
    localparam int Q_W     = SUM_W - K;
    localparam int ACC_W   = INTEG_W + 1;

    localparam logic signed [DIFF_W-1:0]  RND  = DIFF_W'((1 << R) - 1);
    localparam logic signed [DIFF_W-1:0]  E_HI = DIFF_W'(qrpm_pkg::ERR_MAX);
    localparam logic signed [DIFF_W-1:0]  E_LO = DIFF_W'(qrpm_pkg::ERR_MIN);
    localparam logic signed [INTEG_W-1:0] I_HI = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] I_LO = {1'b1, {(INTEG_W-1){1'b0}}};

    // stage 0: error and its difference
    logic signed [DIFF_W-1:0]  d, d_adj, d_q;
    logic signed [ERR_W-1:0]   e_next;
    logic signed [ERR_W:0]     df_next;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [ERR_W-1:0]   e1_reg;
    logic signed [ERR_W:0]     df1_reg;

    // stage 1: products
    logic signed [PROD_W-1:0]  pe_next, ie_next;
    logic signed [DPROD_W-1:0] dd_next;
    logic signed [PROD_W-1:0]  pe2_reg, ie2_reg;
    logic signed [DPROD_W-1:0] dd2_reg;

    // stage 2: pd sum and integrator
    logic signed [PD_W-1:0]    pd_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [PD_W-1:0]    pd3_reg;
    logic signed [INTEG_W-1:0] iv3_reg;

    // stage 3: scaled sum
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   sum4_reg;

    // stage 4: truncate and clamp
    logic signed [Q_W-1:0]     q_floor, q, lim_p, lim_n;
    logic signed [qrpm_pkg::DRIVE_W-1:0] drive_next;
    logic signed [qrpm_pkg::DRIVE_W-1:0] drive_reg;

    always_comb
    begin
        d     = (DIFF_W'(want) <<< R) - DIFF_W'(meas);
        d_adj = d[DIFF_W-1] ? (d + RND) : d;
        d_q   = d_adj >>> R;
        if (d_q > E_HI)
        begin
            e_next = qrpm_pkg::ERR_MAX;
        end
        else if (d_q < E_LO)
        begin
            e_next = qrpm_pkg::ERR_MIN;
        end
        else
        begin
            e_next = ERR_W'(d_q);
        end
        df_next = (ERR_W+1)'(e_next) - (ERR_W+1)'(prev_reg);
    end

    always_comb
    begin
        pe_next = $signed({1'b0, kp}) * e1_reg;
        ie_next = $signed({1'b0, ki}) * e1_reg;
        dd_next = $signed({1'b0, kd}) * df1_reg;
    end

    // integrator saturates at 32 bits
    always_comb
    begin
        pd_next = PD_W'(pe2_reg) + PD_W'(dd2_reg);
        acc     = ACC_W'(integ_reg) + ACC_W'(ie2_reg);
        if (acc[ACC_W-1] != acc[ACC_W-2])
        begin
            integ_next = acc[ACC_W-1] ? I_LO : I_HI;
        end
        else
        begin
            integ_next = INTEG_W'(acc);
        end
    end

    always_comb
    begin
        sum_next = (SUM_W'(pd3_reg) <<< K) + SUM_W'(iv3_reg);
    end

    // divide by 2^K toward zero, then symmetric clamp
    always_comb
    begin
        q_floor = Q_W'(sum4_reg >>> K);
        q       = (sum4_reg[SUM_W-1] && (|sum4_reg[K-1:0])) ? (q_floor + Q_W'(1)) : q_floor;
        lim_p   = Q_W'($signed({1'b0, limit}));
        lim_n   = -lim_p;
        if (q > lim_p)
        begin
            drive_next = qrpm_pkg::DRIVE_W'(lim_p);
        end
        else if (q < lim_n)
        begin
            drive_next = qrpm_pkg::DRIVE_W'(lim_n);
        end
        else
        begin
            drive_next = qrpm_pkg::DRIVE_W'(q);
        end
    end

    // axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (ctl.load[0])
            begin
                prev_reg <= e_next;
            end
            if (ctl.load[2])
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            e1_reg  <= e_next;
            df1_reg <= df_next;
        end
        if (ctl.load[1])
        begin
            pe2_reg <= pe_next;
            ie2_reg <= ie_next;
            dd2_reg <= dd_next;
        end
        if (ctl.load[2])
        begin
            pd3_reg <= pd_next;
            iv3_reg <= integ_next;
        end
        if (ctl.load[3])
        begin
            sum4_reg <= sum_next;
        end
        if (ctl.load[qrpm_pkg::DRIVE_STAGE])
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load[qrpm_pkg::DRIVE_STAGE] |=>
            (drive_reg <= $signed({1'b0, $past(limit)})) &&
            (drive_reg >= -$signed({1'b0, $past(limit)})))
        else $error("axis drive outside its limit");

endmodule

`default_nettype wire

/* hw/rtl/qrpm_mixer.sv */
// qrpm_mixer: x-layout mix of three axis drives into four bounded motor pulses
// output register stage; depends on qrpm_pkg
`default_nettype none

module qrpm_mixer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire qrpm_pkg::pipe_ctl_t                  ctl,
    input  wire logic        [qrpm_pkg::PULSE_W-1:0]  throttle,
    input  wire logic                                 armed,
    input  wire logic signed [qrpm_pkg::DRIVE_W-1:0]  pitch_in,
    input  wire logic signed [qrpm_pkg::DRIVE_W-1:0]  roll_in,
    input  wire logic signed [qrpm_pkg::DRIVE_W-1:0]  yaw_in,
    input  wire logic        [qrpm_pkg::PULSE_W-1:0]  min_pulse,
    input  wire logic        [qrpm_pkg::PULSE_W-1:0]  max_pulse,
    output logic             [qrpm_pkg::PULSE_W-1:0]  motor1_pulse,
    output logic             [qrpm_pkg::PULSE_W-1:0]  motor2_pulse,
    output logic             [qrpm_pkg::PULSE_W-1:0]  motor3_pulse,
    output logic             [qrpm_pkg::PULSE_W-1:0]  motor4_pulse,
    output logic signed      [qrpm_pkg::DRIVE_W-1:0]  pitch_drive,
    output logic signed      [qrpm_pkg::DRIVE_W-1:0]  roll_drive,
    output logic signed      [qrpm_pkg::DRIVE_W-1:0]  yaw_drive
);

    localparam int PW  = qrpm_pkg::PULSE_W;
    localparam int MXW = PW + 3;

    logic signed [MXW-1:0] thr_s, p_s, r_s, y_s, lo_s, hi_s;
    logic signed [MXW-1:0] mix1, mix2, mix3, mix4;
    logic [PW-1:0] m1_next, m2_next, m3_next, m4_next;
    logic [PW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [qrpm_pkg::DRIVE_W-1:0] pd_reg, rd_reg, yd_reg;

    // upper clamp first, lower clamp last so min wins
    function automatic logic [PW-1:0] bound(input logic signed [MXW-1:0] v,
                                            input logic signed [MXW-1:0] lo,
                                            input logic signed [MXW-1:0] hi);
        logic signed [MXW-1:0] t;
        t = (v > hi) ? hi : v;
        t = (t < lo) ? lo : t;
        return PW'(t);
    endfunction

    always_comb
    begin
        thr_s = $signed({3'b000, throttle});
        lo_s  = $signed({3'b000, min_pulse});
        hi_s  = $signed({3'b000, max_pulse});
        p_s   = MXW'(pitch_in);
        r_s   = MXW'(roll_in);
        y_s   = MXW'(yaw_in);
        mix1  = thr_s - r_s + p_s + y_s;
        mix2  = thr_s - r_s - p_s - y_s;
        mix3  = thr_s + r_s - p_s + y_s;
        mix4  = thr_s + r_s + p_s - y_s;
        if (armed)
        begin
            m1_next = bound(mix1, lo_s, hi_s);
            m2_next = bound(mix2, lo_s, hi_s);
            m3_next = bound(mix3, lo_s, hi_s);
            m4_next = bound(mix4, lo_s, hi_s);
        end
        else
        begin
            m1_next = qrpm_pkg::KILL_PULSE;
            m2_next = qrpm_pkg::KILL_PULSE;
            m3_next = qrpm_pkg::KILL_PULSE;
            m4_next = qrpm_pkg::KILL_PULSE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[qrpm_pkg::MIX_STAGE])
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
            pd_reg <= pitch_in;
            rd_reg <= roll_in;
            yd_reg <= yaw_in;
        end
    end

    assign motor1_pulse = m1_reg;
    assign motor2_pulse = m2_reg;
    assign motor3_pulse = m3_reg;
    assign motor4_pulse = m4_reg;
    assign pitch_drive  = pd_reg;
    assign roll_drive   = rd_reg;
    assign yaw_drive    = yd_reg;

    a_kill_all: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load[qrpm_pkg::MIX_STAGE] && !armed |=>
            (m1_reg == qrpm_pkg::KILL_PULSE) && (m2_reg == qrpm_pkg::KILL_PULSE) &&
            (m3_reg == qrpm_pkg::KILL_PULSE) && (m4_reg == qrpm_pkg::KILL_PULSE))
        else $error("disarmed beat without kill pulses");

    a_pulse_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load[qrpm_pkg::MIX_STAGE] && armed && (min_pulse <= max_pulse) |=>
            (m1_reg >= $past(min_pulse)) && (m1_reg <= $past(max_pulse)) &&
            (m4_reg >= $past(min_pulse)) && (m4_reg <= $past(max_pulse)))
        else $error("armed motor pulse outside bounds");

endmodule

`default_nettype wire

/* dv/quad_rate_pid_mixer_unit_checker.sv */
// checker for the quad rate pid mixer: watches the config port and both streams,
// predicts each motor frame and compares it field by field
// depends on qrpm_pkg
module quad_rate_pid_mixer_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [11:0]  cfg_wdata,
    output int           fail_count,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = 2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [11:0]        m1;
        logic [11:0]        m2;
        logic [11:0]        m3;
        logic [11:0]        m4;
        logic signed [10:0] pitch;
        logic signed [10:0] roll;
        logic signed [10:0] yaw;
    } motor_frame_t;

    // shadow registers
    logic [7:0]  kp_pr, kd_pr, kp_y, kd_y, ki;
    logic [9:0]  lim;
    logic [11:0] lo_pulse, hi_pulse;

    // per-axis loop state, 0 pitch, 1 roll, 2 yaw
    longint integ [3];
    longint last_err [3];

    motor_frame_t frames_due [$];
    int faults;

    function automatic longint pid_axis_step(int ax, logic signed [11:0] want,
                                             logic signed [15:0] meas,
                                             logic [7:0] kp, logic [7:0] kd);
        longint w, m, e, acc, sum, l;
        w = longint'(want);
        m = longint'(meas);
        e = (w * 16 - m) / 16;
        if (e > 8191) e = 8191;
        if (e < -8192) e = -8192;
        acc = integ[ax] + longint'(ki) * e;
        if (acc > SAT_HI) acc = SAT_HI;
        if (acc < SAT_LO) acc = SAT_LO;
        integ[ax] = acc;
        sum = (longint'(kp) * e + longint'(kd) * (e - last_err[ax])) * 256 + acc;
        sum = sum / 256;
        last_err[ax] = e;
        l = longint'(lim);
        if (sum > l) sum = l;
        if (sum < -l) sum = -l;
        return sum;
    endfunction

    function automatic logic [11:0] bound_pulse(longint v);
        longint hi, lo;
        hi = longint'(hi_pulse);
        lo = longint'(lo_pulse);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[11:0];
    endfunction

    function automatic motor_frame_t mix_tick(logic [111:0] d);
        motor_frame_t f;
        longint p, r, y, t;
        p = pid_axis_step(0, d[11:0], d[51:36], kp_pr, kd_pr);
        r = pid_axis_step(1, d[23:12], d[67:52], kp_pr, kd_pr);
        y = pid_axis_step(2, d[35:24], d[83:68], kp_y, kd_y);
        t = longint'(d[95:84]);
        f.m1 = bound_pulse(t - r + p + y);
        f.m2 = bound_pulse(t - r - p - y);
        f.m3 = bound_pulse(t + r - p + y);
        f.m4 = bound_pulse(t + r + p - y);
        // disarmed: pulses forced, drives and loop state still follow
        if (d[107:96] < qrpm_pkg::ARM_THRESHOLD)
        begin
            f.m1 = qrpm_pkg::KILL_PULSE;
            f.m2 = qrpm_pkg::KILL_PULSE;
            f.m3 = qrpm_pkg::KILL_PULSE;
            f.m4 = qrpm_pkg::KILL_PULSE;
        end
        f.pitch = p[10:0];
        f.roll  = r[10:0];
        f.yaw   = y[10:0];
        return f;
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            faults++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        motor_frame_t f;
        if (!rst_n)
        begin
            kp_pr    = qrpm_pkg::KP_PR_RST;
            kd_pr    = qrpm_pkg::KD_PR_RST;
            kp_y     = qrpm_pkg::KP_YAW_RST;
            kd_y     = qrpm_pkg::KD_YAW_RST;
            ki       = qrpm_pkg::KI_RST;
            lim      = qrpm_pkg::AXIS_LIM_RST;
            lo_pulse = qrpm_pkg::MIN_PULSE_RST;
            hi_pulse = qrpm_pkg::MAX_PULSE_RST;
            for (int i = 0; i < 3; i++)
            begin
                integ[i]    = 0;
                last_err[i] = 0;
            end
            frames_due.delete();
            faults = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (qrpm_pkg::cfg_reg_t'(cfg_addr))
                    qrpm_pkg::CFG_KP_PITCH_ROLL: kp_pr    = cfg_wdata[7:0];
                    qrpm_pkg::CFG_KD_PITCH_ROLL: kd_pr    = cfg_wdata[7:0];
                    qrpm_pkg::CFG_KP_YAW:        kp_y     = cfg_wdata[7:0];
                    qrpm_pkg::CFG_KD_YAW:        kd_y     = cfg_wdata[7:0];
                    qrpm_pkg::CFG_KI_GAIN:       ki       = cfg_wdata[7:0];
                    qrpm_pkg::CFG_AXIS_LIMIT:    lim      = cfg_wdata[9:0];
                    qrpm_pkg::CFG_MIN_PULSE:     lo_pulse = cfg_wdata;
                    qrpm_pkg::CFG_MAX_PULSE:     hi_pulse = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                frames_due.push_back(mix_tick(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result beat with no frame expected: %h", m_tdata);
                    faults++;
                end
                else
                begin
                    f = frames_due.pop_front();
                    check_field("motor1_pulse", int'(f.m1), int'(m_tdata[11:0]));
                    check_field("motor2_pulse", int'(f.m2), int'(m_tdata[23:12]));
                    check_field("motor3_pulse", int'(f.m3), int'(m_tdata[35:24]));
                    check_field("motor4_pulse", int'(f.m4), int'(m_tdata[47:36]));
                    check_field("pitch_drive", int'(f.pitch),
                                int'($signed(m_tdata[58:48])));
                    check_field("roll_drive", int'(f.roll),
                                int'($signed(m_tdata[69:59])));
                    check_field("yaw_drive", int'(f.yaw),
                                int'($signed(m_tdata[80:70])));
                end
            end
            fail_count  <= faults;
            outstanding <= frames_due.size();
        end
    end

endmodule

/* dv/quad_rate_pid_mixer_unit_tb.sv */
// testbench top for quad_rate_pid_mixer_unit: clock, reset, stimulus, config
// phases and verdict; depends on qrpm_pkg and quad_rate_pid_mixer_unit_checker
module quad_rate_pid_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // drain margin, meant to cover anything still in the pipe
    localparam int DRAIN_CYCLES = 12;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // want_pitch, want_roll, want_yaw, meas_pitch, meas_roll, meas_yaw,
    // throttle, arm_pulse, zero fill
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // motor1..4 pulses, pitch_drive, roll_drive, yaw_drive, zero fill
    logic [87:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [11:0]  cfg_wdata = '0;

    int fail_count;
    int outstanding;

    // set during the burst phase: neither side idles
    bit no_idle = 1'b0;

    quad_rate_pid_mixer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    quad_rate_pid_mixer_unit_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side backpressure, about a third of cycles stalled
    always @(posedge clk)
    begin
        m_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 32);
    end

    // one tick beat; valid stays up across back-to-back beats and only
    // drops when a gap is inserted
    task automatic send_tick(input logic [11:0] wp, wr, wy,
                             input logic [15:0] mp, mr, my,
                             input logic [11:0] thr, arm);
        int gaps;
        gaps = 0;
        while (!no_idle && $urandom_range(0, 99) < 32)
            gaps++;
        if (gaps > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, arm, thr, my, mr, mp, wy, wr, wp};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // measured rate for one axis: mostly close to the wanted rate so the
    // drives are not always clamped, sometimes anything, sometimes extreme
    function automatic logic [15:0] pick_meas(logic signed [11:0] want);
        int v;
        int pick;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r = $urandom;
        if (pick < 60)
        begin
            v = int'(want) * 16 + int'($urandom_range(0, 2047)) - 1024;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        end
        else if (pick < 85)
            return r[15:0];
        else
            return r[0] ? 16'h7fff : 16'h8000;
    endfunction

    task automatic send_random_tick(input bit windup);
        logic [11:0] wp, wr, wy, thr, arm;
        logic [15:0] mp, mr, my;
        logic [31:0] r;
        int pick;
        r = $urandom;
        wp = r[11:0];
        wr = r[23:12];
        r = $urandom;
        wy = r[11:0];
        if (windup)
        begin
            // sustained large error: pitch and roll wind up, yaw winds down
            wp = 12'($urandom_range(2000, 2047));
            wr = 12'($urandom_range(2000, 2047));
            wy = 12'(-int'($urandom_range(2000, 2048)));
            mp = 16'(-int'($urandom_range(32000, 32768)));
            mr = 16'(-int'($urandom_range(32000, 32768)));
            my = 16'($urandom_range(32000, 32767));
        end
        else
        begin
            mp = pick_meas(wp);
            mr = pick_meas(wr);
            my = pick_meas(wy);
        end
        pick = $urandom_range(0, 99);
        r = $urandom;
        thr = (pick < 70) ? 12'($urandom_range(900, 2100)) : r[11:0];
        // arm mostly armed, some near the threshold, the rest anywhere
        pick = $urandom_range(0, 99);
        if (pick < 50)
            arm = 12'($urandom_range(1500, 2000));
        else if (pick < 70)
            arm = 12'($urandom_range(1090, 1110));
        else
            arm = r[23:12];
        send_tick(wp, wr, wy, mp, mr, my, thr, arm);
    endtask

    // let the pipe empty out before touching registers or finishing
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // writes every register; unused upper data bits carry junk, which the
    // block must drop
    task automatic load_settings(input logic [7:0] kp_pr, kd_pr, kp_y, kd_y, ki,
                                 input logic [9:0] lim,
                                 input logic [11:0] lo, hi);
        logic [11:0] junk;
        logic [11:0] vals [8];
        junk = 12'($urandom);
        vals[qrpm_pkg::CFG_KP_PITCH_ROLL] = {junk[3:0], kp_pr};
        vals[qrpm_pkg::CFG_KD_PITCH_ROLL] = {junk[7:4], kd_pr};
        vals[qrpm_pkg::CFG_KP_YAW]        = {junk[11:8], kp_y};
        junk = 12'($urandom);
        vals[qrpm_pkg::CFG_KD_YAW]        = {junk[3:0], kd_y};
        vals[qrpm_pkg::CFG_KI_GAIN]       = {junk[7:4], ki};
        vals[qrpm_pkg::CFG_AXIS_LIMIT]    = {junk[9:8], lim};
        vals[qrpm_pkg::CFG_MIN_PULSE]     = lo;
        vals[qrpm_pkg::CFG_MAX_PULSE]     = hi;
        wait_idle();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= qrpm_pkg::cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_ticks(input int n, input bit windup);
        repeat (n) send_random_tick(windup);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks at reset settings
        // disarmed at rest, loop state still advancing
        send_tick(12'd0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd0);
        // largest positive error on pitch only
        send_tick(12'sd2047, 12'd0, 12'd0, 16'sh8000, 16'd0, 16'd0, 12'd1500, 12'd1500);
        // largest negative error on every axis
        send_tick(-12'sd2048, -12'sd2048, -12'sd2048, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  12'd1500, 12'd2000);
        // fractional measurements that truncate toward zero
        send_tick(12'd0, 12'd0, 12'd0, -16'sd1, 16'sd1, -16'sd17, 12'd1500, 12'd1500);
        send_tick(12'd0, 12'd0, 12'd0, 16'sd17, -16'sd15, 16'sd15, 12'd1500, 12'd1500);
        // throttle extremes against both pulse bounds
        send_tick(12'd0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd4095);
        send_tick(12'd0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd1100);
        // just below the arm threshold
        send_tick(12'sd100, 12'sd100, 12'sd100, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd1099);
        // mixed signs so each motor gets a different blend
        send_tick(12'sd50, -12'sd30, 12'sd20, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1800);
        send_tick(-12'sd40, 12'sd60, -12'sd25, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1800);
        // error back to zero: derivative kick in the other direction
        send_tick(12'd0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1800);
        send_tick(12'sd2047, 12'sd2047, 12'sd2047, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  12'd2048, 12'd4095);
        send_tick(12'd0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 12'd1200, 12'd1100);
        run_ticks(150, 1'b0);

        // all gains zero, no axis authority, widest pulse window
        load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 12'd0, 12'd4095);
        run_ticks(100, 1'b0);

        // everything at its top, min above max so min wins
        load_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd1023,
                      12'd4095, 12'd0);
        run_ticks(100, 1'b0);

        // burst with no idling on either side
        no_idle = 1'b1;
        load_settings(8'd2, 8'd18, 8'd4, 8'd0, 8'd5, 10'd250, 12'd1100, 12'd2000);
        run_ticks(200, 1'b0);
        no_idle = 1'b0;

        // random settings, gains kept mostly small so clamps are not constant
        repeat (5)
        begin
            load_settings(8'($urandom_range(0, 8)), 8'($urandom_range(0, 32)),
                          8'($urandom_range(0, 8)), 8'($urandom_range(0, 16)),
                          8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                          12'($urandom_range(0, 2000)), 12'($urandom_range(1000, 4095)));
            run_ticks(60, 1'b0);
        end

        // integrator windup: drives pitch and roll integrators far positive
        // and the yaw integrator far negative
        load_settings(8'd1, 8'd0, 8'd1, 8'd0, 8'd255, 10'd1023, 12'd1000, 12'd2000);
        run_ticks(650, 1'b1);

        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
